[src/sdwq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sleep deadline wake queue package
// Shared widths, the result limit, function codes, status codes and the empty-queue time.
// ----------------------------------------------------------------------------
package sdwq_pkg;

  localparam int unsigned TIME_W      = 63;
  localparam int unsigned TASK_ID_W   = 8;
  localparam int unsigned MAX_RESULTS = 16;

  // Reported as the earliest wake time while the queue holds no entry.
  localparam logic [TIME_W-1:0] TIME_EMPTY = 63'h7fff_ffff_ffff_ffff;

  localparam logic FUNC_SLEEP = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage : sdwq_pkg
`default_nettype wire

[src/sdwq_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sleep deadline wake queue entry store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sdwq_store
  import sdwq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8,
  localparam int unsigned IDX_W      = $clog2(QUEUE_DEPTH)
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [IDX_W-1:0]   waddr_i,
  input  wire logic [ID_BITS-1:0] wid_i,
  input  wire logic [TIME_W-1:0]  wtime_i,
  input  wire logic [IDX_W-1:0]   raddr_i,
  output logic      [ID_BITS-1:0] rid_o,
  output logic      [TIME_W-1:0]  rtime_o
);

  logic [ID_BITS-1:0] id_mem_q   [QUEUE_DEPTH];
  logic [TIME_W-1:0]  time_mem_q [QUEUE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      id_mem_q[waddr_i]   <= wid_i;
      time_mem_q[waddr_i] <= wtime_i;
    end
    rid_o   <= id_mem_q[raddr_i];
    rtime_o <= time_mem_q[raddr_i];
  end

endmodule : sdwq_store
`default_nettype wire

[src/sleep_deadline_wake_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sleep deadline wake queue
// A queue of sleeping tasks kept sorted by wake time, with a tick command
// that releases the due tasks from the front, at most LIMIT of them.
// ----------------------------------------------------------------------------
// A refused sleep is answered without leaving idle. An accepted sleep walks down from the
// tail, testing one entry at a time; a tick scans the due entries from the front, then
// sends each woken word through a read state and an output state. The single comparator
// and the one read port of the entry store make the walk and the scan test one entry at a
// time. busy drops in the cycle that shows the last word, so the next command can be taken
// then. The receiver cannot stall: each word is valid for one cycle only. Reset empties the
// queue but not the entry store.
// ----------------------------------------------------------------------------
module sleep_deadline_wake_queue
  import sdwq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 func_i,
  input  wire logic [TASK_ID_W-1:0] task_id_i,
  input  wire logic [TIME_W-1:0]    wake_time_i,
  input  wire logic [TIME_W-1:0]    now_time_i,
  output logic                      res_valid_o,
  output logic                      woke_valid_o,
  output logic [TASK_ID_W-1:0]      woke_id_o,
  output logic                      last_o,
  output logic                      status_o,
  output logic [TIME_W-1:0]         earliest_wake_o
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  // Most tasks one tick may release.
  localparam int unsigned LIMIT = (QUEUE_DEPTH < MAX_RESULTS) ? QUEUE_DEPTH : MAX_RESULTS;

  // The queue is a ring in the store: logical entry i sits at head + i.
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_TCK_RD,
    ST_TCK_CMP,
    ST_TCK_FRONT,
    ST_TCK_LOAD,
    ST_WK_RD,
    ST_WK_OUT
  } state_e;

  state_e             state_q;
  logic [IDX_W-1:0]   head_q;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   pos_q;      // insertion slot being tested, walking down
  logic [CNT_W-1:0]   woke_q;     // number of due entries found by a tick
  logic [CNT_W-1:0]   emit_q;     // index of the woken word being sent
  logic [ID_BITS-1:0] id_q;
  logic [TIME_W-1:0]  time_q;     // wake time of a sleep or current time of a tick
  logic [TIME_W-1:0]  earliest_q; // front wake time or TIME_EMPTY; a tick sets it before moving the head

  logic                 res_valid_q;
  logic                 woke_valid_q;
  logic [TASK_ID_W-1:0] woke_id_q;
  logic                 last_q;
  logic                 status_q;
  logic [TIME_W-1:0]    earliest_wake_q;

  logic               accept;
  logic               st_we;
  logic [IDX_W-1:0]   st_waddr;
  logic [ID_BITS-1:0] st_wid;
  logic [TIME_W-1:0]  st_wtime;
  logic [IDX_W-1:0]   st_raddr;
  logic [ID_BITS-1:0] st_rid;
  logic [TIME_W-1:0]  st_rtime;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  sdwq_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wid_i   (st_wid),
    .wtime_i (st_wtime),
    .raddr_i (st_raddr),
    .rid_o   (st_rid),
    .rtime_o (st_rtime)
  );

  // Read address: the entry that the next state compares, loads as the front or sends.
  always_comb begin
    case (state_q)
      ST_INS_RD:                st_raddr = phys(head_q, pos_q - CNT_W'(1));
      ST_TCK_RD, ST_TCK_FRONT:  st_raddr = phys(head_q, woke_q);
      ST_WK_RD:                 st_raddr = phys(head_q, emit_q);
      default:                  st_raddr = head_q;
    endcase
  end

  // Write port. An insertion walks down from the tail, moving every later
  // entry up by one slot, then drops the new entry into the hole.
  always_comb begin
    st_we    = 1'b0;
    st_waddr = phys(head_q, pos_q);
    st_wid   = id_q;
    st_wtime = time_q;
    case (state_q)
      ST_INS_RD: begin
        st_we = (pos_q == '0);
      end
      ST_INS_CMP: begin
        st_we = 1'b1;
        if (st_rtime > time_q) begin
          st_wid   = st_rid;
          st_wtime = st_rtime;
        end
      end
      default: begin
        st_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      pos_q        <= '0;
      woke_q       <= '0;
      emit_q       <= '0;
      earliest_q   <= TIME_EMPTY;
      res_valid_q  <= 1'b0;
      woke_valid_q <= 1'b0;
      woke_id_q    <= '0;
      last_q       <= 1'b0;
      status_q     <= STATUS_OK;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            id_q <= ID_BITS'(task_id_i);
            if (func_i == FUNC_TICK) begin
              time_q  <= now_time_i;
              woke_q  <= '0;
              state_q <= ST_TCK_RD;
            end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
              // Queue full: the sleep is refused and nothing changes.
              res_valid_q     <= 1'b1;
              woke_valid_q    <= 1'b0;
              woke_id_q       <= '0;
              last_q          <= 1'b1;
              status_q        <= STATUS_FULL;
              earliest_wake_q <= earliest_q;
            end else begin
              time_q  <= wake_time_i;
              pos_q   <= count_q;
              state_q <= ST_INS_RD;
            end
          end
        end

        ST_INS_RD: begin
          if (pos_q == '0) begin
            // New entry lands at the front.
            count_q         <= count_q + CNT_W'(1);
            earliest_q      <= time_q;
            res_valid_q     <= 1'b1;
            woke_valid_q    <= 1'b0;
            woke_id_q       <= '0;
            last_q          <= 1'b1;
            status_q        <= STATUS_OK;
            earliest_wake_q <= time_q;
            state_q         <= ST_IDLE;
          end else begin
            state_q <= ST_INS_CMP;
          end
        end

        ST_INS_CMP: begin
          if (st_rtime > time_q) begin
            pos_q   <= pos_q - CNT_W'(1);
            state_q <= ST_INS_RD;
          end else begin
            // Placed behind an equal or earlier entry: the front is unchanged.
            count_q         <= count_q + CNT_W'(1);
            res_valid_q     <= 1'b1;
            woke_valid_q    <= 1'b0;
            woke_id_q       <= '0;
            last_q          <= 1'b1;
            status_q        <= STATUS_OK;
            earliest_wake_q <= earliest_q;
            state_q         <= ST_IDLE;
          end
        end

        ST_TCK_RD: begin
          if ((woke_q < CNT_W'(LIMIT)) && (woke_q < count_q)) begin
            state_q <= ST_TCK_CMP;
          end else begin
            state_q <= ST_TCK_FRONT;
          end
        end

        ST_TCK_CMP: begin
          if (st_rtime <= time_q) begin
            woke_q  <= woke_q + CNT_W'(1);
            state_q <= ST_TCK_RD;
          end else begin
            state_q <= ST_TCK_FRONT;
          end
        end

        ST_TCK_FRONT: begin
          state_q <= ST_TCK_LOAD;
        end

        ST_TCK_LOAD: begin
          // The read issued last cycle is the entry that becomes the front.
          if (count_q == woke_q) begin
            earliest_q      <= TIME_EMPTY;
            earliest_wake_q <= TIME_EMPTY;
          end else begin
            earliest_q      <= st_rtime;
            earliest_wake_q <= st_rtime;
          end
          if (woke_q == '0) begin
            res_valid_q  <= 1'b1;
            woke_valid_q <= 1'b0;
            woke_id_q    <= '0;
            last_q       <= 1'b1;
            status_q     <= STATUS_OK;
            state_q      <= ST_IDLE;
          end else begin
            emit_q  <= '0;
            state_q <= ST_WK_RD;
          end
        end

        ST_WK_RD: begin
          state_q <= ST_WK_OUT;
        end

        ST_WK_OUT: begin
          // The woken entries still sit in the store until the head moves.
          res_valid_q  <= 1'b1;
          woke_valid_q <= 1'b1;
          woke_id_q    <= TASK_ID_W'(st_rid);
          status_q     <= STATUS_OK;
          if (emit_q == woke_q - CNT_W'(1)) begin
            last_q  <= 1'b1;
            head_q  <= phys(head_q, woke_q);
            count_q <= count_q - woke_q;
            state_q <= ST_IDLE;
          end else begin
            last_q  <= 1'b0;
            emit_q  <= emit_q + CNT_W'(1);
            state_q <= ST_WK_RD;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o     = res_valid_q;
  assign woke_valid_o    = woke_valid_q;
  assign woke_id_o       = woke_id_q;
  assign last_o          = last_q;
  assign status_o        = status_q;
  assign earliest_wake_o = earliest_wake_q;

  // The fill level never passes the store depth.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill level beyond depth");

  // An empty queue always reports the empty wake time.
  a_empty_front : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (earliest_q == TIME_EMPTY))
    else $error("empty queue with a pending wake time");

  // A refused sleep leaves the queue untouched.
  a_full_refuse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (func_i == FUNC_SLEEP) && (count_q == CNT_W'(QUEUE_DEPTH)))
      |=> ($stable(count_q) && $stable(head_q) && status_o == STATUS_FULL))
    else $error("full sleep changed the queue");

  // A word that wakes nobody always closes its command.
  a_empty_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !woke_valid_o) |-> last_o)
    else $error("non-wake word without last mark");

endmodule : sleep_deadline_wake_queue
`default_nettype wire

[bench/tb_sleep_deadline_wake_queue.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sleep deadline wake queue testbench
// Drives sleep and tick commands through the start/busy handshake and checks
// every result word against a predictor of the sorted wake queue. A short
// directed table covers the empty queue, time extremes, a full queue with a
// refused sleep and a tick that wakes every entry. Random commands follow,
// mostly wake times near a running tick count so that ticks release tasks.
// ----------------------------------------------------------------------------
module tb_sleep_deadline_wake_queue
  import sdwq_pkg::*;
();

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned IDW          = 8;
  localparam int unsigned WAKE_LIMIT   = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
  localparam int unsigned RANDOM_WORDS = 435;
  localparam int unsigned SETTLE_WORDS = 70;
  localparam int unsigned TAIL_CYCLES  = 80;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam logic [TASK_ID_W-1:0] ID_MASK = TASK_ID_W'((1 << IDW) - 1);

  // One result word as the block shows it on its result ports.
  typedef struct packed {
    logic                 woke_valid;
    logic [TASK_ID_W-1:0] woke_id;
    logic                 last;
    logic                 status;
    logic [TIME_W-1:0]    earliest;
  } wake_res_t;

  // One row of the directed table. When typed is set, the row carries the
  // single result word it must produce, written out by hand.
  typedef struct {
    logic                 func;
    logic [TASK_ID_W-1:0] id;
    logic [TIME_W-1:0]    wake;
    logic [TIME_W-1:0]    now;
    bit                   typed;
    wake_res_t            res;
  } cmd_row_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 start           = 1'b0;
  logic                 busy;
  logic                 func_i          = FUNC_SLEEP;
  logic [TASK_ID_W-1:0] task_id_i       = '0;
  logic [TIME_W-1:0]    wake_time_i     = '0;
  logic [TIME_W-1:0]    now_time_i      = '0;
  logic                 res_valid_o;
  logic                 woke_valid_o;
  logic [TASK_ID_W-1:0] woke_id_o;
  logic                 last_o;
  logic                 status_o;
  logic [TIME_W-1:0]    earliest_wake_o;

  // Travel with the command word so that the monitor knows, at the edge that
  // accepts it, whether a hand-written expectation replaces the predicted one.
  bit                   row_typed = 1'b0;
  wake_res_t            row_res   = '0;

  // Predictor state: the sorted queue of sleeping tasks.
  logic [TASK_ID_W-1:0] slot_id   [DEPTH];
  logic [TIME_W-1:0]    slot_time [DEPTH];
  int unsigned          slot_count = 0;

  wake_res_t            pending_words[$];
  logic [TIME_W-1:0]    tick_clock = 63'd1000;

  int unsigned cycle_count  = 0;
  int unsigned fail_count   = 0;
  int unsigned sleep_count  = 0;
  int unsigned refuse_count = 0;
  int unsigned tick_count   = 0;
  int unsigned woke_count   = 0;

  sleep_deadline_wake_queue #(
    .QUEUE_DEPTH(DEPTH),
    .ID_BITS    (IDW)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .task_id_i      (task_id_i),
    .wake_time_i    (wake_time_i),
    .now_time_i     (now_time_i),
    .res_valid_o    (res_valid_o),
    .woke_valid_o   (woke_valid_o),
    .woke_id_o      (woke_id_o),
    .last_o         (last_o),
    .status_o       (status_o),
    .earliest_wake_o(earliest_wake_o)
  );

  // 8 ns clock period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs or a result never shows up.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d words still expected",
               cycle_count, pending_words.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [TIME_W-1:0] front_time();
    return (slot_count == 0) ? TIME_EMPTY : slot_time[0];
  endfunction

  function automatic logic [TIME_W-1:0] any_time();
    return TIME_W'({$urandom(), $urandom()});
  endfunction

  // Works out the result words of one accepted command and updates the
  // predicted queue. A sleep lands behind every entry with an equal or
  // earlier time; a tick releases due entries from the front, at most
  // WAKE_LIMIT of them.
  task automatic wake_queue_step(input logic f, input logic [TASK_ID_W-1:0] id,
                                 input logic [TIME_W-1:0] wake,
                                 input logic [TIME_W-1:0] now,
                                 input bit typed, input wake_res_t typed_res);
    int unsigned          pos;
    int unsigned          n;
    logic [TASK_ID_W-1:0] released[$];
    wake_res_t            words[$];
    logic [TIME_W-1:0]    head;

    if (f == FUNC_SLEEP) begin
      sleep_count++;
      if (slot_count >= DEPTH) begin
        refuse_count++;
        words.push_back('{1'b0, '0, 1'b1, STATUS_FULL, front_time()});
      end else begin
        pos = 0;
        while (pos < slot_count && slot_time[pos] <= wake) pos++;
        for (int i = slot_count; i > pos; i--) begin
          slot_id[i]   = slot_id[i-1];
          slot_time[i] = slot_time[i-1];
        end
        slot_id[pos]   = id & ID_MASK;
        slot_time[pos] = wake;
        slot_count++;
        words.push_back('{1'b0, '0, 1'b1, STATUS_OK, front_time()});
      end
    end else begin
      tick_count++;
      n = 0;
      while (n < WAKE_LIMIT && n < slot_count && slot_time[n] <= now) begin
        released.push_back(slot_id[n]);
        n++;
      end
      for (int i = n; i < slot_count; i++) begin
        slot_id[i-n]   = slot_id[i];
        slot_time[i-n] = slot_time[i];
      end
      slot_count -= n;
      head = front_time();
      woke_count += n;
      if (n == 0) begin
        words.push_back('{1'b0, '0, 1'b1, STATUS_OK, head});
      end else begin
        foreach (released[k]) begin
          words.push_back('{1'b1, released[k], (k == n - 1), STATUS_OK, head});
        end
      end
    end

    // A hand-written row only ever describes a single-word command.
    if (typed) begin
      pending_words.push_back(typed_res);
    end else begin
      foreach (words[k]) pending_words.push_back(words[k]);
    end
  endtask

  task automatic note_mismatch(input string what, input wake_res_t exp_w,
                               input wake_res_t got_w);
    fail_count++;
    if (fail_count <= 10) begin
      $display("Mismatch at cycle %0d: %s", cycle_count, what);
      $display("  expected valid=%0b id=%02h last=%0b status=%0b earliest=%016h",
               exp_w.woke_valid, exp_w.woke_id, exp_w.last, exp_w.status,
               exp_w.earliest);
      $display("  actual   valid=%0b id=%02h last=%0b status=%0b earliest=%016h",
               got_w.woke_valid, got_w.woke_id, got_w.last, got_w.status,
               got_w.earliest);
    end
  endtask

  // Monitor. Both the result strobe and the handshake are sampled at the
  // rising edge, before the block's own registers move. The result is
  // checked before a new command is predicted, since any word shown at
  // this edge belongs to an earlier command.
  always @(posedge clk_i) begin
    wake_res_t got_w;
    wake_res_t exp_w;
    if (rst_ni) begin
      if (res_valid_o) begin
        got_w = '{woke_valid_o, woke_id_o, last_o, status_o, earliest_wake_o};
        if (pending_words.size() == 0) begin
          note_mismatch("result word with nothing expected", '0, got_w);
        end else begin
          exp_w = pending_words.pop_front();
          if (got_w !== exp_w) note_mismatch("result word differs", exp_w, got_w);
        end
      end
      if (start && !busy) begin
        wake_queue_step(func_i, task_id_i, wake_time_i, now_time_i, row_typed, row_res);
      end
    end
  end

  // Puts one command word on the ports and holds it until the block takes
  // it. Returns at the accepting edge, so the caller may drive the next word
  // or drop start in the same step without a second assignment.
  task automatic issue_word(input logic f, input logic [TASK_ID_W-1:0] id,
                            input logic [TIME_W-1:0] wake,
                            input logic [TIME_W-1:0] now,
                            input bit typed, input wake_res_t res);
    start       <= 1'b1;
    func_i      <= f;
    task_id_i   <= id;
    wake_time_i <= wake;
    now_time_i  <= now;
    row_typed   <= typed;
    row_res     <= res;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Holds the sender off until every expected word has arrived.
  task automatic wait_all_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  // Random command. Most sleeps pick a wake time a little ahead of a running
  // tick count and most ticks advance that count, so that ticks do wake
  // tasks. The rest are extreme or fully random times; a sleep far in the
  // future sits in the queue and helps it fill up. Fields that the command
  // does not use still carry random values.
  task automatic make_random_word(input int unsigned sleep_pct, output logic f,
                                  output logic [TASK_ID_W-1:0] id,
                                  output logic [TIME_W-1:0] wake,
                                  output logic [TIME_W-1:0] now);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    f    = ($urandom_range(0, 99) < sleep_pct) ? FUNC_SLEEP : FUNC_TICK;
    id   = TASK_ID_W'($urandom());
    wake = any_time();
    now  = any_time();
    if (f == FUNC_SLEEP) begin
      if (roll < 78) wake = tick_clock + TIME_W'($urandom_range(0, 60));
      else if (roll < 85) wake = tick_clock;
      else if (roll < 90) wake = TIME_EMPTY;
      else if (roll < 92) wake = '0;
    end else begin
      if (roll < 85) begin
        tick_clock = tick_clock + TIME_W'($urandom_range(0, 25));
        now = tick_clock;
      end else if (roll < 90) begin
        now = TIME_EMPTY;
      end else if (roll < 93) begin
        now = '0;
      end
    end
  endtask

  initial begin
    cmd_row_t             dir_rows[$];
    cmd_row_t             r;
    logic                 f;
    logic [TASK_ID_W-1:0] id;
    logic [TIME_W-1:0]    wake;
    logic [TIME_W-1:0]    now;
    int unsigned          sent;
    int unsigned          burst;
    int unsigned          sleep_pct;

    // Directed table. Rows with a typed word: empty-queue ticks at both time
    // extremes, a sleep and wake at time zero, a sleep at the largest time
    // that is then not due one tick early but due exactly on time. Then the
    // queue is filled with repeated and out-of-order times, one more sleep is
    // refused, and a tick at the largest time wakes every entry in order.
    dir_rows.push_back('{FUNC_TICK, 8'h00, '0, '0, 1'b1,
                         '{1'b0, 8'h00, 1'b1, STATUS_OK, TIME_EMPTY}});
    dir_rows.push_back('{FUNC_TICK, 8'h00, '0, TIME_EMPTY, 1'b1,
                         '{1'b0, 8'h00, 1'b1, STATUS_OK, TIME_EMPTY}});
    dir_rows.push_back('{FUNC_SLEEP, 8'h00, '0, TIME_EMPTY, 1'b1,
                         '{1'b0, 8'h00, 1'b1, STATUS_OK, 63'd0}});
    dir_rows.push_back('{FUNC_TICK, 8'hFF, TIME_EMPTY, '0, 1'b1,
                         '{1'b1, 8'h00, 1'b1, STATUS_OK, TIME_EMPTY}});
    dir_rows.push_back('{FUNC_SLEEP, 8'hFF, TIME_EMPTY, '0, 1'b1,
                         '{1'b0, 8'h00, 1'b1, STATUS_OK, TIME_EMPTY}});
    dir_rows.push_back('{FUNC_TICK, 8'h00, '0, TIME_EMPTY - 63'd1, 1'b1,
                         '{1'b0, 8'h00, 1'b1, STATUS_OK, TIME_EMPTY}});
    dir_rows.push_back('{FUNC_TICK, 8'h00, '0, TIME_EMPTY, 1'b1,
                         '{1'b1, 8'hFF, 1'b1, STATUS_OK, TIME_EMPTY}});
    for (int i = 0; i < DEPTH; i++) begin
      dir_rows.push_back('{FUNC_SLEEP, TASK_ID_W'(8'h3C + i * 11),
                           TIME_W'(((i * 3) % 5) * 1000 + 10), '0, 1'b0, '0});
    end
    // The earliest of the fill times is 10.
    dir_rows.push_back('{FUNC_SLEEP, 8'hFF, '0, '0, 1'b1,
                         '{1'b0, 8'h00, 1'b1, STATUS_FULL, 63'd10}});
    dir_rows.push_back('{FUNC_TICK, 8'h00, '0, TIME_EMPTY, 1'b0, '0});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      r = dir_rows[k];
      issue_word(r.func, r.id, r.wake, r.now, r.typed, r.res);
      if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 3));
    end
    wait_all_results();

    // Random part: bursts of commands with random gaps. Each burst leans toward
    // ticks, mixes the two or leans toward sleeps, so that the queue both fills and drains.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 12);
      case ($urandom_range(0, 2))
        0:       sleep_pct = 30;
        1:       sleep_pct = 55;
        default: sleep_pct = 85;
      endcase
      for (int k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
        make_random_word(sleep_pct, f, id, wake, now);
        issue_word(f, id, wake, now, 1'b0, '0);
        sent++;
        if (sent % SETTLE_WORDS == 0) wait_all_results();
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 10));
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d directed and %0d random commands: %0d sleeps (%0d refused as full),",
             dir_rows.size(), sent, sleep_count, refuse_count);
    $display("%0d ticks waking %0d tasks; %0d mismatches in %0d cycles.",
             tick_count, woke_count, fail_count, cycle_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule : tb_sleep_deadline_wake_queue
